[hdl/slxfp_pkg.sv]
`default_nettype none

package slxfp_pkg;

    localparam int unsigned ByteWidth     = 8;
    localparam int unsigned PosWidth      = 9;
    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 9;

    // sync, length and message id come before the first payload word
    localparam logic [PosWidth-1:0] FrontOverhead = 9'd3;
    localparam logic [PosWidth-1:0] PosHunt       = 9'd0;
    localparam logic [PosWidth-1:0] PosLength     = 9'd1;
    localparam logic [PosWidth-1:0] PosMessageId  = 9'd2;

    localparam logic [ByteWidth-1:0] SyncByteReset   = 8'd164;
    localparam logic [PosWidth-1:0]  PosLimitReset   = 9'd64;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_SYNC_BYTE = 2'd0,
        REG_POS_LIMIT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CKFAIL   = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

endpackage

`default_nettype wire

[hdl/sync_length_xor_frame_parser_unit.sv]
// A word accepted goes first into the input register, and its result (if any) is loaded
// into the result register once that register is free.
// Throughput: one word per cycle, sustained, with out_ready held high.
// The input register takes a new word while a finished result still waits downstream.
// Reset (rst_n low, asynchronous): sync hunting, checksum cleared, both registers empty,
// sync byte 164 and position limit 64.
`default_nettype none

module sync_length_xor_frame_parser_unit
    import slxfp_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     cfg_we,
    input  wire logic [CfgIndexWidth-1:0] cfg_index,
    input  wire logic [CfgDataWidth-1:0]  cfg_data,

    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [ByteWidth-1:0]     rx_byte,

    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          kind,
    output logic [1:0]                    status,
    output logic [ByteWidth-1:0]          payload_byte,
    output logic [ByteWidth-1:0]          payload_index,
    output logic [ByteWidth-1:0]          message_id,
    output logic [ByteWidth-1:0]          frame_length
);

    // configuration
    logic [ByteWidth-1:0] sync_byte_reg;
    logic [PosWidth-1:0]  pos_limit_reg;

    // input stage
    logic                 in_valid_reg;
    logic [ByteWidth-1:0] in_byte_reg;

    // parser state
    logic [PosWidth-1:0]  frame_pos_reg, frame_pos_next;
    logic [ByteWidth-1:0] xor_reg, xor_next;
    logic [ByteWidth-1:0] length_reg, length_next;
    logic [ByteWidth-1:0] msg_id_reg, msg_id_next;

    // result stage
    logic                 out_valid_reg;
    kind_t                kind_reg, kind_next;
    status_t              status_reg, status_next;
    logic [ByteWidth-1:0] data_reg;
    logic [ByteWidth-1:0] index_reg, index_next;
    logic [ByteWidth-1:0] res_msg_id_reg;
    logic [ByteWidth-1:0] res_length_reg;

    logic                 advance;
    logic                 emit;
    logic [ByteWidth-1:0] xor_with_byte;
    logic [PosWidth-1:0]  end_pos;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign xor_with_byte = xor_reg ^ in_byte_reg;
    assign end_pos       = PosWidth'(length_reg) + FrontOverhead;

    always_comb
    begin
        frame_pos_next = frame_pos_reg;
        xor_next       = xor_reg;
        length_next    = length_reg;
        msg_id_next    = msg_id_reg;
        emit           = 1'b0;
        kind_next      = KIND_PAYLOAD;
        status_next    = ST_OK;
        index_next     = '0;

        if (frame_pos_reg == PosHunt) begin
            // drop everything until the sync word
            if (in_byte_reg == sync_byte_reg) begin
                xor_next       = in_byte_reg;
                frame_pos_next = PosLength;
            end
        end else if (frame_pos_reg == PosLength) begin
            xor_next       = xor_with_byte;
            length_next    = in_byte_reg;
            frame_pos_next = PosMessageId;
        end else if (frame_pos_reg == PosMessageId) begin
            xor_next       = xor_with_byte;
            msg_id_next    = in_byte_reg;
            frame_pos_next = FrontOverhead;
        end else if (frame_pos_reg > pos_limit_reg) begin
            emit           = 1'b1;
            kind_next      = KIND_STATUS;
            status_next    = ST_OVERFLOW;
            xor_next       = '0;
            frame_pos_next = PosHunt;
        end else if (frame_pos_reg == end_pos) begin
            emit           = 1'b1;
            kind_next      = KIND_STATUS;
            status_next    = (xor_with_byte == '0) ? ST_OK : ST_CKFAIL;
            xor_next       = '0;
            frame_pos_next = PosHunt;
        end else begin
            emit           = 1'b1;
            xor_next       = xor_with_byte;
            index_next     = ByteWidth'(frame_pos_reg - FrontOverhead);
            frame_pos_next = frame_pos_reg + PosWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sync_byte_reg <= SyncByteReset;
            pos_limit_reg <= PosLimitReset;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SYNC_BYTE: sync_byte_reg <= cfg_data[ByteWidth-1:0];
                REG_POS_LIMIT: pos_limit_reg <= cfg_data[PosWidth-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            frame_pos_reg <= PosHunt;
            xor_reg       <= '0;
            length_reg    <= '0;
            msg_id_reg    <= '0;
        end else if (advance) begin
            frame_pos_reg <= frame_pos_next;
            xor_reg       <= xor_next;
            length_reg    <= length_next;
            msg_id_reg    <= msg_id_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the result until taken; load only when a word produces one
    always_ff @(posedge clk)
    begin
        if (advance && emit) begin
            kind_reg       <= kind_next;
            status_reg     <= status_next;
            data_reg       <= in_byte_reg;
            index_reg      <= index_next;
            res_msg_id_reg <= msg_id_next;
            res_length_reg <= length_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign status        = status_reg;
    assign payload_byte  = data_reg;
    assign payload_index = index_reg;
    assign message_id    = res_msg_id_reg;
    assign frame_length  = res_length_reg;

`ifndef ASSERT_OFF
    a_hunt_xor_clear: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pos_reg == PosHunt |-> xor_reg == '0)
        else $error("checksum not cleared while hunting");

    a_payload_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_PAYLOAD |-> status_reg == ST_OK
            && index_reg == ByteWidth'(PosWidth'(index_reg)))
        else $error("payload word carries a status");

    a_body_word_emits: assert property (@(posedge clk) disable iff (!rst_n)
        advance && frame_pos_reg >= FrontOverhead |=> out_valid_reg)
        else $error("frame body word gave no result");

    a_status_returns_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit && kind_next == KIND_STATUS |=> frame_pos_reg == PosHunt)
        else $error("parser did not return to hunting after status");

    a_input_held_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input word lost while result stage was full");
`endif

endmodule

`default_nettype wire
